@@ hw/rtl/hbrl_pkg.sv @@
// Shared types and constants for the H-bridge reversal lockout PWM core.
`timescale 1ns / 1ps

package hbrl_pkg;

    // Field and register widths fixed by the interface.
    localparam int SPEED_W   = 16;
    localparam int DUTY_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CARRIER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD    = 1'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] CARRIER_RESET = 16'd3000;
    localparam logic [CFG_W-1:0] DEAD_RESET    = 16'd5;

    // What a motor does on one tick.
    typedef enum logic [1:0] {
        MODE_STOP,
        MODE_BRAKE,
        MODE_DRIVE
    } t_mode;

    // Per-stage load enables of the duty pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_pipe_en;

endpackage

@@ hw/rtl/hbrl_motor.sv @@
// One motor: lockout counters, mode decision and the duty arithmetic pipeline.
`timescale 1ns / 1ps

module hbrl_motor #(
    parameter int SPEED_MAX  = 1000,
    parameter int BRAKE_CODE = 32767
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  hbrl_pkg::t_pipe_en                   i_en,
    input  logic signed [hbrl_pkg::SPEED_W-1:0]  i_speed,
    input  logic [hbrl_pkg::CFG_W-1:0]           i_carrier,
    input  logic [hbrl_pkg::CFG_W-1:0]           i_dead,
    output logic [hbrl_pkg::DUTY_W-1:0]          o_fwd_duty,
    output logic [hbrl_pkg::DUTY_W-1:0]          o_rvs_duty
);

    localparam int DW    = hbrl_pkg::DUTY_W;
    localparam int MAG_W = $clog2(SPEED_MAX + 1);
    localparam int P_W   = MAG_W + DW;
    // Reciprocal of SPEED_MAX; the quotient it gives is exact or one short.
    localparam int SHIFT = P_W;
    localparam int RW    = SHIFT + 1;
    localparam int PR_W  = P_W + RW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / 64'(SPEED_MAX));
    localparam logic [P_W-1:0] DIVISOR = P_W'(SPEED_MAX);
    localparam logic signed [hbrl_pkg::SPEED_W:0] SMAX_POS = (hbrl_pkg::SPEED_W + 1)'(SPEED_MAX);
    localparam logic signed [hbrl_pkg::SPEED_W:0] SMAX_NEG = -SMAX_POS;
    localparam logic signed [hbrl_pkg::SPEED_W-1:0] BRAKE_V = hbrl_pkg::SPEED_W'(BRAKE_CODE);

    // Lockout counters.
    logic [hbrl_pkg::CFG_W-1:0] r_fwd_lock, n_fwd_lock;
    logic [hbrl_pkg::CFG_W-1:0] r_rvs_lock, n_rvs_lock;
    logic [hbrl_pkg::CFG_W-1:0] fwd_dec, rvs_dec;

    // Decision for the incoming beat.
    hbrl_pkg::t_mode n_mode;
    logic signed [hbrl_pkg::SPEED_W:0] req_ext;
    logic signed [hbrl_pkg::SPEED_W:0] req_neg;
    logic [MAG_W-1:0] n_mag;
    logic out_of_range;

    // Pipeline registers.
    hbrl_pkg::t_mode  r_s1_mode, r_s2_mode, r_s3_mode, r_s4_mode;
    logic             r_s1_fwd, r_s2_fwd, r_s3_fwd, r_s4_fwd;
    logic [DW-1:0]    r_s1_car, r_s2_car, r_s3_car, r_s4_car;
    logic [MAG_W-1:0] r_s1_mag;
    logic [P_W-1:0]   r_s2_prod, r_s3_prod, r_s4_prod;
    logic [DW-1:0]    r_s3_q0, r_s4_q0;
    logic [P_W-1:0]   r_s4_qd;
    logic [DW-1:0]    r_fwd_duty, r_rvs_duty;

    logic [PR_W-1:0]  recip_prod;
    logic [P_W-1:0]   rem;
    logic [DW-1:0]    quot;
    logic [DW-1:0]    drive_duty;

    // Counters first step down, saturating at zero, then a drive reloads the other side.
    always_comb begin
        fwd_dec      = (r_fwd_lock != '0) ? r_fwd_lock - 1'b1 : r_fwd_lock;
        rvs_dec      = (r_rvs_lock != '0) ? r_rvs_lock - 1'b1 : r_rvs_lock;
        n_fwd_lock   = fwd_dec;
        n_rvs_lock   = rvs_dec;
        req_ext      = {i_speed[hbrl_pkg::SPEED_W-1], i_speed};
        req_neg      = -req_ext;
        out_of_range = (req_ext > SMAX_POS) || (req_ext < SMAX_NEG);
        n_mag        = i_speed[hbrl_pkg::SPEED_W-1] ? req_neg[MAG_W-1:0] : req_ext[MAG_W-1:0];
        if (i_speed == '0) begin
            n_mode = hbrl_pkg::MODE_STOP;
        end else if (i_speed == BRAKE_V) begin
            n_mode = hbrl_pkg::MODE_BRAKE;
        end else if (!i_speed[hbrl_pkg::SPEED_W-1]) begin
            if (fwd_dec != '0) begin
                n_mode = hbrl_pkg::MODE_BRAKE;
            end else begin
                n_rvs_lock = i_dead;
                n_mode     = out_of_range ? hbrl_pkg::MODE_BRAKE : hbrl_pkg::MODE_DRIVE;
            end
        end else begin
            if (rvs_dec != '0) begin
                n_mode = hbrl_pkg::MODE_BRAKE;
            end else begin
                n_fwd_lock = i_dead;
                n_mode     = out_of_range ? hbrl_pkg::MODE_BRAKE : hbrl_pkg::MODE_DRIVE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_lock <= '0;
            r_rvs_lock <= '0;
        end else if (i_en.s1) begin
            r_fwd_lock <= n_fwd_lock;
            r_rvs_lock <= n_rvs_lock;
        end
    end

    // Stage 1: decision and magnitude; the carrier is taken with the beat.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_mode <= n_mode;
            r_s1_fwd  <= !i_speed[hbrl_pkg::SPEED_W-1];
            r_s1_mag  <= n_mag;
            r_s1_car  <= i_carrier;
        end
    end

    // Stage 2: magnitude times carrier.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_mode <= r_s1_mode;
            r_s2_fwd  <= r_s1_fwd;
            r_s2_car  <= r_s1_car;
            r_s2_prod <= P_W'(r_s1_mag) * P_W'(r_s1_car);
        end
    end

    // Stage 3: estimate of the quotient by the reciprocal.
    assign recip_prod = PR_W'(r_s2_prod) * PR_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_mode <= r_s2_mode;
            r_s3_fwd  <= r_s2_fwd;
            r_s3_car  <= r_s2_car;
            r_s3_prod <= r_s2_prod;
            r_s3_q0   <= recip_prod[SHIFT +: DW];
        end
    end

    // Stage 4: estimate times divisor, for the remainder check.
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_s4_mode <= r_s3_mode;
            r_s4_fwd  <= r_s3_fwd;
            r_s4_car  <= r_s3_car;
            r_s4_prod <= r_s3_prod;
            r_s4_q0   <= r_s3_q0;
            r_s4_qd   <= P_W'(r_s3_q0) * DIVISOR;
        end
    end

    // Stage 5: correct the quotient by one where needed and form the compare values.
    always_comb begin
        rem        = r_s4_prod - r_s4_qd;
        quot       = r_s4_q0 + DW'(rem >= DIVISOR);
        drive_duty = r_s4_car - quot;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            case (r_s4_mode)
                hbrl_pkg::MODE_STOP: begin
                    r_fwd_duty <= r_s4_car;
                    r_rvs_duty <= r_s4_car;
                end
                hbrl_pkg::MODE_DRIVE: begin
                    r_fwd_duty <= r_s4_fwd ? drive_duty : r_s4_car;
                    r_rvs_duty <= r_s4_fwd ? r_s4_car : drive_duty;
                end
                default: begin
                    r_fwd_duty <= '0;
                    r_rvs_duty <= '0;
                end
            endcase
        end
    end

    assign o_fwd_duty = r_fwd_duty;
    assign o_rvs_duty = r_rvs_duty;

endmodule

@@ hw/rtl/hbridge_reversal_lockout_pwm_core.sv @@
// Top level of the two-motor H-bridge duty calculator with reversal lockout.
`timescale 1ns / 1ps

// Each input beat is one control tick carrying a signed speed request for the left and the
// right motor; each tick gives exactly one output beat with four PWM compare values, where the
// carrier period means that side is off. A new tick is accepted every clock cycle unless a
// stalled output has filled the pipeline. The lockout counters are updated in the accepting
// cycle, and the duty arithmetic (one product, a reciprocal multiply and a remainder
// correction) runs through four further registered stages. Empty stages close up, so a stalled
// output only stops input once the pipeline is full. Configuration writes take effect on the
// next accepted tick and should be made while the pipeline is empty.
module hbridge_reversal_lockout_pwm_core #(
    parameter int SPEED_MAX  = 1000,
    parameter int BRAKE_CODE = 32767
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [hbrl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hbrl_pkg::CFG_W-1:0]         i_cfg_wdata,
    // Tick requests
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,  // left_speed, right_speed
    // Compare values
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [63:0]                        m_axis_tdata   // left_fwd_duty, left_rvs_duty,
                                                              // right_fwd_duty, right_rvs_duty
);

    localparam int SW = hbrl_pkg::SPEED_W;

    logic [hbrl_pkg::CFG_W-1:0] r_carrier;
    logic [hbrl_pkg::CFG_W-1:0] r_dead;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    hbrl_pkg::t_pipe_en en;

    logic [hbrl_pkg::DUTY_W-1:0] left_fwd, left_rvs, right_fwd, right_rvs;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier <= hbrl_pkg::CARRIER_RESET;
            r_dead    <= hbrl_pkg::DEAD_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hbrl_pkg::CFG_CARRIER: r_carrier <= i_cfg_wdata;
                hbrl_pkg::CFG_DEAD:    r_dead    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on this cycle; stage 1 also needs a valid input.
    always_comb begin
        en.s5 = !r_v5 || m_axis_tready;
        en.s4 = !r_v4 || en.s5;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = (!r_v1 || en.s2) && s_axis_tvalid;
    end

    assign s_axis_tready = !r_v1 || en.s2;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s_axis_tready) r_v1 <= s_axis_tvalid;
            if (en.s2)         r_v2 <= r_v1;
            if (en.s3)         r_v3 <= r_v2;
            if (en.s4)         r_v4 <= r_v3;
            if (en.s5)         r_v5 <= r_v4;
        end
    end

    // One lockout and duty pipeline per motor.
    hbrl_motor #(
        .SPEED_MAX  (SPEED_MAX),
        .BRAKE_CODE (BRAKE_CODE)
    ) u_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_speed    (s_axis_tdata[SW-1:0]),
        .i_carrier  (r_carrier),
        .i_dead     (r_dead),
        .o_fwd_duty (left_fwd),
        .o_rvs_duty (left_rvs)
    );

    hbrl_motor #(
        .SPEED_MAX  (SPEED_MAX),
        .BRAKE_CODE (BRAKE_CODE)
    ) u_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_speed    (s_axis_tdata[2*SW-1:SW]),
        .i_carrier  (r_carrier),
        .i_dead     (r_dead),
        .o_fwd_duty (right_fwd),
        .o_rvs_duty (right_rvs)
    );

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {right_rvs, right_fwd, left_rvs, left_fwd};

endmodule
